### rtl/domain_name_validator_core_assert.svh
// ----------------------------------------------------------------------------
// domain_name_validator_core_assert
// Assertion macros for the domain name validator core.
// ----------------------------------------------------------------------------
`ifndef DOMAIN_NAME_VALIDATOR_CORE_ASSERT_SVH
`define DOMAIN_NAME_VALIDATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DNV_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dnv assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DNV_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dnv assertion failed");

`endif

### rtl/dnv_pkg.sv
// ----------------------------------------------------------------------------
// dnv_pkg
// Shared types and constants for the domain name validator.
// ----------------------------------------------------------------------------
`default_nettype none

package dnv_pkg;

    localparam logic [7:0] MIN_NAME_LEN  = 8'd3;
    localparam logic [7:0] MAX_NAME_LEN  = 8'd128;
    localparam logic [6:0] MAX_LABEL_LEN = 7'd63;
    localparam logic [7:0] CNT_SAT       = 8'hFF;
    localparam logic [6:0] LABEL_SAT     = 7'h7F;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    typedef enum logic [3:0] {
        ST_OK             = 4'd0,
        ST_SHORT          = 4'd1,
        ST_LONG           = 4'd2,
        ST_LEAD_DOT       = 4'd3,
        ST_DOUBLE_DOT     = 4'd4,
        ST_LABEL_LONG     = 4'd5,
        ST_STAR_NO_DOT    = 4'd6,
        ST_STAR_NOT_FIRST = 4'd7,
        ST_ILLEGAL        = 4'd8,
        ST_NO_DOTS        = 4'd9,
        ST_TRAIL_DOT      = 4'd10
    } status_t;

    typedef struct packed {
        logic is_dot;
        logic is_star;
        logic plain_legal;
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic        last;
    } step_t;

endpackage

`default_nettype wire

### rtl/dnv_char_class.sv
// ----------------------------------------------------------------------------
// dnv_char_class
// Classifies one raw byte: dot, star, and plain hostname character.
// ----------------------------------------------------------------------------
`default_nettype none

module dnv_char_class (
    input  wire logic [7:0]          char_byte,
    output dnv_pkg::char_class_t     cls
);
    import dnv_pkg::*;

    logic is_lower;
    logic is_upper;
    logic is_digit;

    assign is_lower = (char_byte >= 8'h61) && (char_byte <= 8'h7A);
    assign is_upper = (char_byte >= 8'h41) && (char_byte <= 8'h5A);
    assign is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);

    assign cls.is_dot      = (char_byte == CH_DOT);
    assign cls.is_star     = (char_byte == CH_STAR);
    assign cls.plain_legal = is_lower || is_upper || is_digit ||
                             (char_byte == CH_DASH) || (char_byte == CH_DOT);

endmodule

`default_nettype wire

### rtl/dnv_name_tracker.sv
// ----------------------------------------------------------------------------
// dnv_name_tracker
// Per-name state (counts, dot and star flags, first error) and the final
// status code for the item that ends a name.
// ----------------------------------------------------------------------------
`default_nettype none

module dnv_name_tracker (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step_en,
    input  wire dnv_pkg::step_t  step,
    input  wire logic            wildcard_enable,
    output dnv_pkg::status_t     status
);
    import dnv_pkg::*;

    logic [7:0] char_count_reg,   char_count_next;
    logic       dot_seen_reg,     dot_seen_next;
    logic [6:0] label_length_reg, label_length_next;
    status_t    first_error_reg,  first_error_next;
    logic       star_pending_reg, star_pending_next;

    logic       first_pos;
    status_t    err;

    always_comb begin
        first_pos         = (char_count_reg == 8'd0);
        err               = first_error_reg;
        dot_seen_next     = dot_seen_reg;
        label_length_next = label_length_reg;
        star_pending_next = 1'b0;

        // a pending leading star must be followed by a dot
        if (star_pending_reg && !step.cls.is_dot && err == ST_OK) begin
            err = ST_STAR_NO_DOT;
        end

        if (step.cls.is_dot) begin
            dot_seen_next     = 1'b1;
            label_length_next = 7'd0;
            if (err == ST_OK) begin
                if (first_pos) begin
                    err = ST_LEAD_DOT;
                end else if (label_length_reg == 7'd0) begin
                    err = ST_DOUBLE_DOT;
                end else if (label_length_reg > MAX_LABEL_LEN) begin
                    err = ST_LABEL_LONG;
                end
            end
        end else if (label_length_reg != LABEL_SAT) begin
            label_length_next = label_length_reg + 7'd1;
        end

        if (!step.cls.plain_legal) begin
            if (wildcard_enable && step.cls.is_star) begin
                if (first_pos) begin
                    star_pending_next = 1'b1;
                end else if (err == ST_OK) begin
                    err = ST_STAR_NOT_FIRST;
                end
            end else if (err == ST_OK) begin
                err = ST_ILLEGAL;
            end
        end

        char_count_next = (char_count_reg != CNT_SAT) ? char_count_reg + 8'd1
                                                      : char_count_reg;

        // one-character name that is just a star
        if (step.last && star_pending_next && err == ST_OK) begin
            err = ST_STAR_NO_DOT;
        end
        first_error_next = err;

        if (char_count_next < MIN_NAME_LEN) begin
            status = ST_SHORT;
        end else if (char_count_next > MAX_NAME_LEN) begin
            status = ST_LONG;
        end else if (err != ST_OK) begin
            status = err;
        end else if (!dot_seen_next) begin
            status = ST_NO_DOTS;
        end else if (label_length_next == 7'd0) begin
            status = ST_TRAIL_DOT;
        end else if (label_length_next > MAX_LABEL_LEN) begin
            status = ST_LABEL_LONG;
        end else begin
            status = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_count_reg   <= 8'd0;
            dot_seen_reg     <= 1'b0;
            label_length_reg <= 7'd0;
            first_error_reg  <= ST_OK;
            star_pending_reg <= 1'b0;
        end else if (step_en) begin
            if (step.last) begin
                char_count_reg   <= 8'd0;
                dot_seen_reg     <= 1'b0;
                label_length_reg <= 7'd0;
                first_error_reg  <= ST_OK;
                star_pending_reg <= 1'b0;
            end else begin
                char_count_reg   <= char_count_next;
                dot_seen_reg     <= dot_seen_next;
                label_length_reg <= label_length_next;
                first_error_reg  <= first_error_next;
                star_pending_reg <= star_pending_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/domain_name_validator_core.sv
// Result path: m_valid rises once a last character, accepted into the input
// register, moves on to the result register; a full result slot can hold it back.
// Throughput: one character item per cycle; a stalled result holds back only a
// last character, which then blocks the input; earlier characters keep flowing.
// Reset: synchronous active-low aresetn clears both valid flags, all per-name
// state and wildcard_enable; no result is pending after reset.
// ----------------------------------------------------------------------------
// domain_name_validator_core
// Byte-serial DNS host name syntax checker; one status code per name.
// ----------------------------------------------------------------------------
`default_nettype none

module domain_name_validator_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_wildcard_enable,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_byte,
    input  wire logic        s_last_char,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_status_code
);
    import dnv_pkg::*;

    logic        wildcard_reg;
    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic        last_reg;
    logic        out_valid_reg;
    logic [3:0]  status_reg;

    logic        advance;
    char_class_t cls;
    step_t       step;
    status_t     status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wildcard_reg <= 1'b0;
        end else if (cfg_valid) begin
            wildcard_reg <= cfg_wildcard_enable;
        end
    end

    // a non-last item never needs the result slot
    assign advance = in_valid_reg && (!last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            char_reg <= s_char_byte;
            last_reg <= s_last_char;
        end
    end

    dnv_char_class u_class (
        .char_byte (char_reg),
        .cls       (cls)
    );

    assign step.cls  = cls;
    assign step.last = last_reg;

    dnv_name_tracker u_tracker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step_en         (advance),
        .step            (step),
        .wildcard_enable (wildcard_reg),
        .status          (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && last_reg) begin
            status_reg <= status;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status_code = status_reg;

`include "domain_name_validator_core_assert.svh"

    `DNV_ASSERT_NOW(a_no_overwrite, aclk, aresetn, out_valid_reg && !m_ready, !(advance && last_reg))
    `DNV_ASSERT_NEXT(a_last_gives_result, aclk, aresetn, advance && last_reg, out_valid_reg)
    `DNV_ASSERT_NOW(a_stall_means_full, aclk, aresetn, !s_ready, in_valid_reg && last_reg && out_valid_reg)
    `DNV_ASSERT_NOW(a_code_range, aclk, aresetn, out_valid_reg, status_reg <= ST_TRAIL_DOT)

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for domain_name_validator_core. Host names are streamed one
// character per item under random source gaps and sink stalls. A scoreboard
// tracks the per-name state, predicts one status code per name and compares
// it with each accepted result. One long sink hold-off fills the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import dnv_pkg::*;

    logic       aclk                = 1'b0;
    logic       aresetn             = 1'b0;
    logic       cfg_valid           = 1'b0;
    logic       cfg_ready;
    logic       cfg_wildcard_enable = 1'b0;
    logic       s_valid             = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_byte         = 8'h00;
    logic       s_last_char         = 1'b0;
    logic       m_valid;
    logic       m_ready             = 1'b0;
    logic [3:0] m_status_code;

    bit pace_on  = 1'b1;   // random gaps and stalls
    bit hold_req = 1'b0;   // one long sink hold-off

    class name_checker;
        bit         wc_en;
        logic [7:0] n_chars;
        bit         dot_seen;
        logic [6:0] lbl_len;
        status_t    first_err;
        bit         star_wait;
        status_t    expected_q[$];
        int         mismatches;

        function new();
            wc_en      = 1'b0;
            mismatches = 0;
            clear_name();
        endfunction

        function void clear_name();
            n_chars   = '0;
            dot_seen  = 1'b0;
            lbl_len   = '0;
            first_err = ST_OK;
            star_wait = 1'b0;
        endfunction

        function void flag(status_t code);
            if (first_err == ST_OK) begin
                first_err = code;
            end
        endfunction

        function void note_char(logic [7:0] ch, bit last);
            bit      at_start;
            bit      legal;
            status_t code;
            at_start = (n_chars == 8'd0);
            legal = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") ||
                    (ch >= "0" && ch <= "9") || ch == CH_DASH || ch == CH_DOT;

            // a leading star must be followed right away by a dot
            if (star_wait) begin
                star_wait = 1'b0;
                if (ch != CH_DOT) begin
                    flag(ST_STAR_NO_DOT);
                end
            end

            if (ch == CH_DOT) begin
                dot_seen = 1'b1;
                if (at_start) begin
                    flag(ST_LEAD_DOT);
                end else if (lbl_len == 7'd0) begin
                    flag(ST_DOUBLE_DOT);
                end else if (lbl_len > MAX_LABEL_LEN) begin
                    flag(ST_LABEL_LONG);
                end
                lbl_len = '0;
            end else if (lbl_len < LABEL_SAT) begin
                lbl_len++;
            end

            if (!legal) begin
                if (wc_en && ch == CH_STAR) begin
                    if (at_start) begin
                        star_wait = 1'b1;
                    end else begin
                        flag(ST_STAR_NOT_FIRST);
                    end
                end else begin
                    flag(ST_ILLEGAL);
                end
            end

            if (n_chars < CNT_SAT) begin
                n_chars++;
            end
            if (!last) begin
                return;
            end

            if (star_wait) begin
                flag(ST_STAR_NO_DOT);
            end
            if (n_chars < MIN_NAME_LEN) begin
                code = ST_SHORT;
            end else if (n_chars > MAX_NAME_LEN) begin
                code = ST_LONG;
            end else if (first_err != ST_OK) begin
                code = first_err;
            end else if (!dot_seen) begin
                code = ST_NO_DOTS;
            end else if (lbl_len == 7'd0) begin
                code = ST_TRAIL_DOT;
            end else if (lbl_len > MAX_LABEL_LEN) begin
                code = ST_LABEL_LONG;
            end else begin
                code = ST_OK;
            end
            expected_q.push_back(code);
            clear_name();
        endfunction

        function void check_status(logic [3:0] got);
            status_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected status %0d with no name pending", got);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("status mismatch: expected %s (%0d), got %0d",
                             want.name(), want, got);
                end
            end
        endfunction
    endclass

    name_checker sb;

    domain_name_validator_core i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_wildcard_enable (cfg_wildcard_enable),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_char_byte         (s_char_byte),
        .s_last_char         (s_last_char),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status_code       (m_status_code)
    );

    initial begin
        forever begin
            #2 aclk = ~aclk;
        end
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    // result sink: random stall bursts plus one long hold-off on request
    initial begin
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 1'b0;
            end else if (pace_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_status(m_status_code);
        end
    end

    task automatic write_wildcard(bit en);
        cfg_valid           <= 1'b1;
        cfg_wildcard_enable <= en;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.wc_en = en;
    endtask

    task automatic send_char(logic [7:0] ch, bit last);
        if (pace_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_byte <= ch;
        s_last_char <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_char(ch, last);
    endtask

    task automatic send_name(ref logic [7:0] nm[$]);
        for (int i = 0; i < nm.size(); i++) begin
            send_char(nm[i], i == nm.size() - 1);
        end
    endtask

    task automatic send_str(string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    // let all pending names drain before touching the register
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [7:0] label_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26) begin
            return 8'("a" + r);
        end else if (r < 52) begin
            return 8'("A" + r - 26);
        end else if (r < 62) begin
            return 8'("0" + r - 52);
        end
        return CH_DASH;
    endfunction

    // mostly well-formed names of mixed length, some damaged, some noise
    task automatic build_name(ref logic [7:0] nm[$]);
        int kind;
        int target;
        int ll;
        int pos;
        nm.delete();
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
            repeat ($urandom_range(1, 10)) nm.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (kind < 60) begin
            target = $urandom_range(3, 24);
        end else if (kind < 72) begin
            target = $urandom_range(1, 4);
        end else if (kind < 88) begin
            target = $urandom_range(25, 127);
        end else if (kind < 98) begin
            target = $urandom_range(126, 131);
        end else begin
            target = $urandom_range(250, 300);
        end

        if (sb.wc_en && $urandom_range(0, 3) == 0) begin
            nm.push_back(CH_STAR);
            nm.push_back(CH_DOT);
        end
        while (nm.size() < target) begin
            case ($urandom_range(0, 9))
                0: begin
                    ll = $urandom_range(60, 66);
                end
                1: begin
                    ll = $urandom_range(120, 135);
                end
                default: begin
                    ll = $urandom_range(1, 10);
                end
            endcase
            repeat (ll) begin
                if (nm.size() < target) begin
                    nm.push_back(label_char());
                end
            end
            if (nm.size() < target) begin
                nm.push_back(CH_DOT);
            end
        end

        if ($urandom_range(0, 9) < 3) begin
            pos = $urandom_range(0, nm.size() - 1);
            case ($urandom_range(0, 3))
                0: begin
                    nm[pos] = CH_DOT;
                end
                1: begin
                    nm[pos] = CH_STAR;
                end
                2: begin
                    nm[pos] = 8'($urandom_range(0, 255));
                end
                default: begin
                    nm[pos] = CH_DASH;
                end
            endcase
        end
    endtask

    task automatic run_names(int budget);
        logic [7:0] nm[$];
        int         sent;
        sent = 0;
        while (sent < budget) begin
            build_name(nm);
            send_name(nm);
            sent += nm.size();
        end
    endtask

    initial begin
        logic [7:0] nm[$];
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        write_wildcard(1'b0);
        send_str("A.z");
        send_str(".9-");
        send_str("a..b");
        send_str("ab.");
        send_str("xyz");
        nm = '{8'hFF, CH_DOT, 8'h00};
        send_name(nm);
        settle();

        write_wildcard(1'b1);
        send_str("*.Z");
        send_str("*a.");
        send_str("a*.");
        send_str("*");
        settle();

        run_names(350);
        settle();
        write_wildcard(1'b0);
        hold_req = 1'b1;
        run_names(350);
        settle();
        write_wildcard(1'b1);
        run_names(350);
        settle();
        pace_on = 1'b0;
        write_wildcard(1'b0);
        run_names(300);
        settle();

        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
